// ===== rtl/sidrc_pkg.sv =====
// Shared constants and types for the sequence insert/delete/range-count block.
package sidrc_pkg;

  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);

  localparam int POS_W    = 13;
  localparam int RPOS_W   = 12;
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 13;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // one write port (enabled by we) and one read port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== rtl/sequence_insert_delete_range_count.sv =====
// Top level: sequencer that shifts and scans the element store one entry per cycle.
// Insert at p with length L moves entries p..L-1 up one slot; append (p == L) moves nothing.
// Delete at p moves entries p+1..L-1 down one slot; delete of the last element moves nothing.
// Query scans the range clamped to the length and counts hits; an empty range gives 0.
// One transaction in flight; the memory read/write port paces every shift and scan.
// Reset (async, active low) empties the sequence; store contents are not cleared.
module sequence_insert_delete_range_count (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [12:0] position, [24:13] right_position, [56:25] value, [63:57] zero
  input  logic [63:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [12:0] count, [15:13] zero
  output logic [15:0] m_axis_tdata
);
  import sidrc_pkg::*;

  // compare width wide enough for position, length and right end + 1
  localparam int CW = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e              state_q;
  logic [1:0]          op_q;
  logic [LEN_W-1:0]    pos_q;
  logic [VAL_W-1:0]    val_q;
  logic [LEN_W-1:0]    cur_q;
  logic [LEN_W-1:0]    last_q;
  logic                rd_vld_q;
  logic [ADDR_W-1:0]   rd_addr_q;
  logic [LEN_W-1:0]    len_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic                out_vld_q;
  logic [COUNT_W-1:0]  out_cnt_q;

  ram_req_t            ram_req;
  logic [VAL_W-1:0]    ram_rdata;

  // input fields
  logic [1:0]          in_op;
  logic [POS_W-1:0]    in_pos;
  logic [RPOS_W-1:0]   in_rpos;
  logic [VAL_W-1:0]    in_val;

  logic [CW-1:0]       pos_x, len_x, end_x, rend_x;
  logic                ins_ok, del_ok, qry_ok;
  logic                accept;
  logic                hit;
  logic                out_load;

  assign in_op   = s_axis_tuser;
  assign in_pos  = s_axis_tdata[POS_W-1:0];
  assign in_rpos = s_axis_tdata[POS_W+RPOS_W-1:POS_W];
  assign in_val  = s_axis_tdata[POS_W+RPOS_W+VAL_W-1:POS_W+RPOS_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(16-COUNT_W){1'b0}}, out_cnt_q};

  // query count moves to the output register once it is free or being drained
  assign out_load = (state_q == S_FINISH) && (op_q == OP_QUERY) &&
                    (!out_vld_q || m_axis_tready);

  // legality checks and clamped query end (exclusive)
  always_comb begin
    pos_x  = CW'(in_pos);
    len_x  = CW'(len_q);
    rend_x = CW'(in_rpos) + CW'(1);
    end_x  = (rend_x < len_x) ? rend_x : len_x;
    ins_ok = (len_x < CW'(CAPACITY)) && (pos_x <= len_x);
    del_ok = pos_x < len_x;
    qry_ok = pos_x < end_x;
  end

  // returned element vs threshold
  assign hit = $signed(ram_rdata) <= $signed(val_q);

  // memory port: reads follow cur_q during a scan; shifted data is written one
  // slot up (insert) or down (delete) as its read data comes back
  always_comb begin
    ram_req.raddr = cur_q[ADDR_W-1:0];
    ram_req.we    = 1'b0;
    ram_req.waddr = rd_addr_q + ADDR_W'(1);
    ram_req.wdata = ram_rdata;
    if (rd_vld_q && (op_q == OP_INSERT)) begin
      ram_req.we    = 1'b1;
    end else if (rd_vld_q && (op_q == OP_DELETE)) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = rd_addr_q - ADDR_W'(1);
    end else if ((state_q == S_FINISH) && (op_q == OP_INSERT)) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = pos_q[ADDR_W-1:0];
      ram_req.wdata = val_q;
    end
  end

  sidrc_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_vld_q  <= 1'b0;
      len_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      // read data comes back the cycle after each scan read
      rd_vld_q <= (state_q == S_SCAN);
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end

      // count returned elements of a query scan
      if (rd_vld_q && (op_q == OP_QUERY) && hit && (cnt_q != {COUNT_W{1'b1}})) begin
        cnt_q <= cnt_q + COUNT_W'(1);
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q  <= in_op;
            pos_q <= pos_x[LEN_W-1:0];
            val_q <= in_val;
            cnt_q <= '0;
            if (in_op == OP_INSERT && ins_ok) begin
              if (pos_x == len_x) begin
                state_q <= S_FINISH;        // append, nothing to move
              end else begin
                cur_q   <= len_q - LEN_W'(1);
                last_q  <= pos_x[LEN_W-1:0];
                state_q <= S_SCAN;
              end
            end else if (in_op == OP_DELETE && del_ok) begin
              if (pos_x + CW'(1) == len_x) begin
                state_q <= S_FINISH;        // last element, nothing to move
              end else begin
                cur_q   <= pos_x[LEN_W-1:0] + LEN_W'(1);
                last_q  <= len_q - LEN_W'(1);
                state_q <= S_SCAN;
              end
            end else if (in_op == OP_QUERY) begin
              if (qry_ok) begin
                cur_q   <= pos_x[LEN_W-1:0];
                last_q  <= end_x[LEN_W-1:0] - LEN_W'(1);
                state_q <= S_SCAN;
              end else begin
                state_q <= S_FINISH;        // empty range, count 0
              end
            end
          end
        end
        S_SCAN: begin
          rd_addr_q <= cur_q[ADDR_W-1:0];
          if (cur_q == last_q) begin
            state_q <= S_DRAIN;
          end else if (op_q == OP_INSERT) begin
            cur_q <= cur_q - LEN_W'(1);     // insert moves top down
          end else begin
            cur_q <= cur_q + LEN_W'(1);
          end
        end
        S_DRAIN: begin
          state_q <= S_FINISH;              // last read data handled this cycle
        end
        S_FINISH: begin
          if (op_q == OP_INSERT) begin
            len_q   <= len_q + LEN_W'(1);
            state_q <= S_IDLE;
          end else if (op_q == OP_DELETE) begin
            len_q   <= len_q - LEN_W'(1);
            state_q <= S_IDLE;
          end else if (out_load) begin
            out_cnt_q <= cnt_q;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sidrc_ram.sv =====
// Element store: one write and one read port, read data registered.
module sidrc_ram (
  input  logic                                clk_i,
  input  sidrc_pkg::ram_req_t                 req_i,
  output logic [sidrc_pkg::VAL_W-1:0]         rdata_o
);
  import sidrc_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule
